// ----- design/ltkt_pkg.sv -----
// shared constants and types for the lru timestamp key table
// no dependencies; imported by lru_timestamp_key_table
package ltkt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam int KEY_W   = 32;
	localparam int TICK_W  = 32;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;

	localparam int IN_W    = KEY_W + TICK_W;
	localparam int OUT_W   = 16;
	localparam int OUT_USED = 1 + SLOT_W + 1 + COUNT_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [TICK_W-1:0] stamp;
		logic [KEY_W-1:0]  key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/ltkt_ram.sv -----
// simple dual-port synchronous ram, one write and one read port
// read data registered, valid the cycle after the address; no dependencies
module ltkt_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- design/lru_timestamp_key_table.sv -----
// Fully associative key table with last-seen stamps and least-recently-seen
// replacement. Keys and stamps share one entry memory with a single read port;
// an item walks the valid entries one per cycle looking for its key, and when
// the table is full and the key is new, walks all entries again for the oldest
// stamp (lowest index on ties). A new key into an empty table skips the search
// and goes straight to the write. The write and its result wait while the
// previous result is still waiting on m_tready. One item is in work at a time;
// the result register lets the next item start while a result waits to be taken.
// Depends on ltkt_pkg and ltkt_ram.
module lru_timestamp_key_table
	import ltkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // key_value[31:0], now_tick[63:32]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // was_hit[0], slot_index[4:1], evicted_old[5],
	                                    // occupied_count[10:6], zero[15:11]
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SCAN,
		ST_WRITE
	} state_t;

	state_t              state_q;
	logic [KEY_W-1:0]    key_q;
	logic [TICK_W-1:0]   now_q;
	cnt_t                fill_q;
	cnt_t                ptr_q;
	logic                rd_vld_s1;
	idx_t                idx_s1;
	logic [TICK_W-1:0]   min_q;
	idx_t                min_idx_q;
	idx_t                slot_q;
	logic                hit_q;
	logic                evict_q;

	logic                out_vld_q;
	logic                out_hit_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic                out_evict_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic                issue;
	idx_t                rd_addr;
	entry_t              rd_entry;
	entry_t              wr_entry;
	logic                wr_en;
	logic                key_match;
	logic                last_search;
	logic                last_scan;
	logic                take_new;
	logic                out_free;
	cnt_t                new_fill;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(OUT_W - OUT_USED)'(0), out_count_q, out_evict_q, out_slot_q, out_hit_q};

	assign rd_addr = ptr_q[IDX_W-1:0];
	assign issue   = ((state_q == ST_SEARCH) && (ptr_q < fill_q)) ||
	                 ((state_q == ST_SCAN) && (ptr_q < cnt_t'(ENTRIES)));

	assign key_match   = (rd_entry.key == key_q);
	assign last_search = ((cnt_t'(idx_s1) + cnt_t'(1)) == fill_q);
	assign last_scan   = (idx_s1 == idx_t'(ENTRIES - 1));
	assign take_new    = (idx_s1 == '0) || (rd_entry.stamp < min_q);

	assign out_free = !out_vld_q || m_tready;
	assign wr_en    = (state_q == ST_WRITE) && out_free;
	assign new_fill = (hit_q || evict_q) ? fill_q : fill_q + cnt_t'(1);

	always_comb begin
		wr_entry.key   = key_q;
		wr_entry.stamp = now_q;
	end

	ltkt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES),
		.ADDR_W(IDX_W)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(slot_q),
		.wr_data(wr_entry),
		.rd_addr(rd_addr),
		.rd_data(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !wr_en) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			idx_s1    <= rd_addr;
			if (issue) begin
				ptr_q <= ptr_q + cnt_t'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						key_q   <= s_tdata[KEY_W-1:0];
						now_q   <= s_tdata[IN_W-1:KEY_W];
						ptr_q   <= '0;
						hit_q   <= 1'b0;
						evict_q <= 1'b0;
						if (fill_q == '0) begin
							slot_q  <= '0;
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (rd_vld_s1) begin
						if (key_match) begin
							slot_q    <= idx_s1;
							hit_q     <= 1'b1;
							state_q   <= ST_WRITE;
						end else if (last_search) begin
							if (fill_q < cnt_t'(ENTRIES)) begin
								slot_q  <= fill_q[IDX_W-1:0];
								state_q <= ST_WRITE;
							end else begin
								ptr_q   <= '0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (take_new) begin
							min_q     <= rd_entry.stamp;
							min_idx_q <= idx_s1;
						end
						if (last_scan) begin
							slot_q  <= take_new ? idx_s1 : min_idx_q;
							evict_q <= 1'b1;
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (out_free) begin
						out_vld_q   <= 1'b1;
						out_hit_q   <= hit_q;
						out_slot_q  <= SLOT_W'(slot_q);
						out_evict_q <= evict_q;
						out_count_q <= COUNT_W'(new_fill);
						fill_q      <= new_fill;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_t'(ENTRIES))
		else $error("fill count above table size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + cnt_t'(1)))
		else $error("fill count moved by more than one");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && evict_q) |-> (fill_q == cnt_t'(ENTRIES)))
		else $error("eviction while table not full");

	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_hit_q && out_evict_q))
		else $error("result flags both hit and eviction");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("accepted transaction not started");

endmodule
